// ----- rtl/adsr_pkg.sv -----
// ----------------------------------------------------------------------------
// ADSR envelope package
// Shared codes, the rate table in milliseconds and the status record of the
// iterative remainder unit.
// ----------------------------------------------------------------------------
package adsr_pkg;

  // Envelope phase codes as reported on the result stream.
  localparam logic [1:0] PH_ATTACK  = 2'd0;
  localparam logic [1:0] PH_DECAY   = 2'd1;
  localparam logic [1:0] PH_RELEASE = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] CFG_ATTACK  = 3'd0;
  localparam logic [2:0] CFG_DECAY   = 3'd1;
  localparam logic [2:0] CFG_SUSTAIN = 3'd2;
  localparam logic [2:0] CFG_RELEASE = 3'd3;
  localparam logic [2:0] CFG_ENABLE  = 3'd4;

  // Step rates in milliseconds; entry zero is replaced by a period of one.
  localparam int unsigned RATE_MS [16] = '{
    0, 8, 16, 24, 38, 56, 68, 80, 100, 250, 500, 800, 1000, 3000, 5000, 8000
  };

  // Status of the remainder unit toward the sequencer.
  typedef struct packed {
    logic done;      // one-cycle pulse when the remainder is ready
    logic rem_zero;  // remainder equals zero
  } mod_status_t;

  // Step period in samples for a rate index, evaluated at elaboration only.
  function automatic int unsigned period_of(int unsigned sample_rate, int k);
    longint unsigned p;
    if (k == 0) begin
      return 1;
    end
    p = longint'(RATE_MS[k]) * longint'(sample_rate) / 256 / 1000;
    if (p == 0) begin
      p = 1;
    end
    return int'(p);
  endfunction

endpackage

// ----- rtl/adsr_envelope_generator_core.sv -----
// ----------------------------------------------------------------------------
// ADSR envelope generator core
// Eight-bit attack / decay-sustain / release envelope stepped by sample ticks.
//
//  Channel | Direction | Signals                               | Content
//  --------+-----------+---------------------------------------+---------------------
//  s_axis  | in        | tvalid, tready, tdata[7:0], tuser      | gate level, mode
//  m_axis  | out       | tvalid, tready, tdata[15:0]            | level, phase, hold
//  cfg     | in        | cfg_valid_i, cfg_ready_o, index, data  | register writes
//
//  For a tick item the position modulo the step period is formed by the
//  bit-serial remainder unit, one bit a cycle. One item is in work at a time.
//  The result register lets the next item enter while a result waits; a
//  stalled result delays only the finish of the following item.
//  Reset is asynchronous and clears all envelope state; no clearing pass.
// ----------------------------------------------------------------------------
module adsr_envelope_generator_core #(
  parameter int unsigned SAMPLE_RATE = 44100
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input items.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [0] gate_level, [7:1] zero
  input  logic        s_axis_tuser,   // [0] mode
  // Result items.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] envelope_level, [9:8] phase_code,
                                      // [10] held_at_zero, [15:11] zero
  // Configuration writes.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [3:0]  cfg_data_i
);

  localparam int unsigned PosW   = $clog2(SAMPLE_RATE + 1);
  localparam int unsigned MaxPer = 3 * adsr_pkg::period_of(SAMPLE_RATE, 15);
  localparam int unsigned PerW   = $clog2(MaxPer + 1);

  // Sequencer codes.
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MOD  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]      state_q, state_d;
  logic [7:0]      level_q, level_d;
  logic [1:0]      phase_q, phase_d;
  logic            hold_q, hold_d;
  logic            gate_q, gate_d;
  logic [PerW-1:0] period_q, period_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [PosW-1:0] pos_inc;

  logic [3:0]      attack_rate_q, decay_rate_q, sustain_q, release_rate_q;
  logic            enable_q;

  logic            m_valid_q, m_valid_d;
  logic [15:0]     m_data_q, m_data_d;

  logic            in_acc;
  logic            mod_start;
  adsr_pkg::mod_status_t mod_st;

  logic [PerW-1:0] att_tab [16];
  logic [PerW-1:0] tri_tab [16];
  logic [7:0]      sustain_lvl;
  logic [7:0]      step_lvl;
  logic [1:0]      step_phase;
  logic [PerW-1:0] step_period;
  logic            step_hold;

  // Period tables fixed at elaboration: attack uses the entry, others triple it.
  for (genvar k = 0; k < 16; k++) begin : g_tab
    assign att_tab[k] = PerW'(adsr_pkg::period_of(SAMPLE_RATE, k));
    assign tri_tab[k] = PerW'(3 * adsr_pkg::period_of(SAMPLE_RATE, k));
  end

  // Configuration registers; writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attack_rate_q  <= 4'd0;
      decay_rate_q   <= 4'd9;
      sustain_q      <= 4'd0;
      release_rate_q <= 4'd0;
      enable_q       <= 1'b1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        adsr_pkg::CFG_ATTACK:  attack_rate_q  <= cfg_data_i;
        adsr_pkg::CFG_DECAY:   decay_rate_q   <= cfg_data_i;
        adsr_pkg::CFG_SUSTAIN: sustain_q      <= cfg_data_i;
        adsr_pkg::CFG_RELEASE: release_rate_q <= cfg_data_i;
        adsr_pkg::CFG_ENABLE:  enable_q       <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign mod_start     = in_acc && !s_axis_tuser;

  // Shared remainder unit: sample position modulo the step period.
  adsr_mod_unit #(
    .DVD_W (PosW),
    .DIV_W (PerW)
  ) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (pos_q),
    .divisor_i  (period_q),
    .status_o   (mod_st)
  );

  // One envelope step, used when the remainder comes out zero.
  assign sustain_lvl = {sustain_q, sustain_q};

  always_comb begin
    step_lvl    = level_q;
    step_phase  = phase_q;
    step_period = period_q;
    step_hold   = hold_q;
    if (!hold_q) begin
      case (phase_q)
        adsr_pkg::PH_ATTACK: begin
          if (level_q != 8'hFF) begin
            step_lvl = level_q + 8'd1;
          end
          if (step_lvl == 8'hFF) begin
            step_phase  = adsr_pkg::PH_DECAY;
            step_period = tri_tab[decay_rate_q];
          end
        end
        adsr_pkg::PH_DECAY: begin
          if (level_q != sustain_lvl && level_q != 8'd0) begin
            step_lvl = level_q - 8'd1;
          end
        end
        default: begin
          if (level_q != 8'd0) begin
            step_lvl = level_q - 8'd1;
          end
        end
      endcase
      if (step_lvl == 8'd0) begin
        step_hold = 1'b1;
      end
    end
  end

  // Position advance with wrap at the sample rate.
  assign pos_inc = pos_q + PosW'(1);

  // Sequencer and envelope state update.
  always_comb begin
    state_d   = state_q;
    level_d   = level_q;
    phase_d   = phase_q;
    hold_d    = hold_q;
    gate_d    = gate_q;
    period_d  = period_q;
    pos_d     = pos_q;
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (s_axis_tuser) begin
            if (!gate_q && s_axis_tdata[0]) begin
              phase_d  = adsr_pkg::PH_ATTACK;
              period_d = att_tab[attack_rate_q];
              hold_d   = 1'b0;
            end else if (gate_q && !s_axis_tdata[0]) begin
              phase_d  = adsr_pkg::PH_RELEASE;
              period_d = tri_tab[release_rate_q];
            end
            gate_d  = s_axis_tdata[0];
            state_d = ST_EMIT;
          end else begin
            state_d = ST_MOD;
          end
        end
      end
      ST_MOD: begin
        if (mod_st.done) begin
          if (enable_q && period_q != '0 && mod_st.rem_zero) begin
            level_d  = step_lvl;
            phase_d  = step_phase;
            period_d = step_period;
            hold_d   = step_hold;
          end
          pos_d   = (pos_inc >= PosW'(SAMPLE_RATE)) ? '0 : pos_inc;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = {5'd0, hold_q, phase_q, (enable_q ? level_q : 8'hFF)};
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      level_q   <= 8'd0;
      phase_q   <= adsr_pkg::PH_RELEASE;
      hold_q    <= 1'b1;
      gate_q    <= 1'b0;
      period_q  <= tri_tab[0];
      pos_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      level_q   <= level_d;
      phase_q   <= phase_d;
      hold_q    <= hold_d;
      gate_q    <= gate_d;
      period_q  <= period_d;
      pos_q     <= pos_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_data_q <= m_data_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // While the hold flag is set the level sits at zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni) hold_q |-> (level_q == 8'd0))
    else $error("hold flag set with nonzero level");

  // The level moves by at most one per update.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (level_d == level_q) || (level_d == level_q + 8'd1) || (level_d == level_q - 8'd1))
    else $error("level jumped by more than one");

  // A finished remainder always moves the sequencer on to emit the result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mod_st.done && state_q == ST_MOD) |=> (state_q == ST_EMIT))
    else $error("remainder result not consumed");

  // The remainder unit only reports while a tick item is in work.
  assert property (@(posedge clk_i) disable iff (!rst_ni) mod_st.done |-> (state_q == ST_MOD))
    else $error("remainder done outside of tick processing");

endmodule

// ----- rtl/adsr_mod_unit.sv -----
// ----------------------------------------------------------------------------
// ADSR remainder unit
// Restoring bit-serial remainder: one dividend bit is shifted in per cycle,
// and the done pulse is raised once the last dividend bit has been shifted in.
// ----------------------------------------------------------------------------
module adsr_mod_unit #(
  parameter int unsigned DVD_W = 16,
  parameter int unsigned DIV_W = 13
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DVD_W-1:0]      dividend_i,
  input  logic [DIV_W-1:0]      divisor_i,
  output adsr_pkg::mod_status_t status_o
);

  localparam int unsigned CntW = (DVD_W > 1) ? $clog2(DVD_W) : 1;

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [DVD_W-1:0] dvd_q, dvd_d;
  logic [DIV_W-1:0] div_q, div_d;
  logic [DIV_W-1:0] rem_q, rem_d;
  logic [DIV_W:0]   rem_sh;
  logic [DIV_W:0]   rem_sub;

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  assign rem_sh  = {rem_q, dvd_q[DVD_W-1]};
  assign rem_sub = rem_sh - {1'b0, div_q};

  // Step sequencing.
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    div_d  = div_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = dividend_i;
      div_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      rem_d = (rem_sh >= {1'b0, div_q}) ? rem_sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];
      dvd_d = dvd_q << 1;
      cnt_d = cnt_q + CntW'(1);
      if (cnt_q == CntW'(DVD_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    div_q <= div_d;
    rem_q <= rem_d;
  end

  assign status_o.done     = done_q;
  assign status_o.rem_zero = (rem_q == '0);

  // A new operation is never started while one is running.
  assert property (@(posedge clk_i) disable iff (!rst_ni) start_i |-> !busy_q)
    else $error("remainder unit restarted while busy");

  // The done pulse follows the last step of a running operation.
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_q |-> !busy_q)
    else $error("done raised while still busy");

  // The partial remainder stays below the divisor once the divisor is nonzero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && div_q != '0) |-> (rem_q < div_q))
    else $error("partial remainder out of range");

endmodule
